// ----- hw/rtl/kts_pkg.sv -----
// kts_pkg: shared constants, types and datapath command codes of the key and tag sorter
package kts_pkg;

  localparam int MAX_PAIRS = 64;
  localparam int IDX_W     = $clog2(MAX_PAIRS);
  localparam int CNT_W     = $clog2(MAX_PAIRS + 1);
  localparam int KEY_W     = 32;
  localparam int TAG_W     = 16;

  localparam int OP_W = 3;
  localparam logic [OP_W-1:0] OP_NONE   = 3'd0;
  localparam logic [OP_W-1:0] OP_READ_I = 3'd1;
  localparam logic [OP_W-1:0] OP_LOAD_I = 3'd2;
  localparam logic [OP_W-1:0] OP_CMP    = 3'd3;
  localparam logic [OP_W-1:0] OP_WB     = 3'd4;
  localparam logic [OP_W-1:0] OP_EMIT   = 3'd5;

  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic [TAG_W-1:0]        tag;
  } pair_t;

  typedef struct packed {
    logic            store;
    logic            close;
    logic [OP_W-1:0] op;
  } cmd_t;

  typedef struct packed {
    logic fill_nonzero;
    logic inner_last;
    logic outer_last;
    logic emit_last;
  } sts_t;

endpackage

// ----- hw/rtl/kts_datapath.sv -----
// kts_datapath: pair memory, index counters, compare and swap, result registers
module kts_datapath import kts_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  cmd_t                    cmd_i,
  output sts_t                    sts_o,
  input  logic signed [KEY_W-1:0] sort_key_i,
  input  logic [TAG_W-1:0]        payload_tag_i,
  output logic signed [KEY_W-1:0] sorted_key_o,
  output logic [TAG_W-1:0]        sorted_tag_o,
  output logic                    end_of_run_o,
  output logic                    result_valid_o
);

  pair_t pair_mem [MAX_PAIRS];

  logic [CNT_W-1:0] fill_q, fill_d;
  logic [CNT_W-1:0] n_q, n_d;
  logic [IDX_W-1:0] i_q, i_d;
  logic [IDX_W-1:0] j_q, j_d;
  logic [IDX_W-1:0] k_q, k_d;
  pair_t            ri_q, ri_d;
  pair_t            rdata_q;
  logic             valid_q, valid_d;
  logic             end_q, end_d;

  logic             not_full;
  logic [IDX_W-1:0] rd_addr;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  pair_t            wr_data;
  logic             swap;

  assign not_full = fill_q < CNT_W'(MAX_PAIRS);
  assign swap     = ri_q.key > rdata_q.key;

  assign sts_o.fill_nonzero = fill_q != '0;
  assign sts_o.inner_last   = (CNT_W'(j_q) + CNT_W'(1)) == n_q;
  assign sts_o.outer_last   = (CNT_W'(i_q) + CNT_W'(2)) == n_q;
  assign sts_o.emit_last    = (CNT_W'(k_q) + CNT_W'(1)) == n_q;

  always_comb begin
    fill_d  = fill_q;
    n_d     = n_q;
    i_d     = i_q;
    j_d     = j_q;
    k_d     = k_q;
    ri_d    = ri_q;
    valid_d = 1'b0;
    end_d   = 1'b0;
    rd_addr = k_q;
    wr_en   = 1'b0;
    wr_addr = fill_q[IDX_W-1:0];
    wr_data.key = sort_key_i;
    wr_data.tag = payload_tag_i;

    if (cmd_i.store && not_full) begin
      wr_en  = 1'b1;
      fill_d = fill_q + CNT_W'(1);
    end
    if (cmd_i.close) begin
      n_d    = fill_q + CNT_W'(not_full);
      fill_d = '0;
      i_d    = '0;
      j_d    = IDX_W'(1);
      k_d    = '0;
    end

    unique case (cmd_i.op)
      OP_NONE: begin
      end
      OP_READ_I: begin
        rd_addr = i_q;
      end
      OP_LOAD_I: begin
        ri_d    = rdata_q;
        rd_addr = j_q;
      end
      OP_CMP: begin
        if (swap) begin
          wr_en   = 1'b1;
          wr_addr = j_q;
          wr_data = ri_q;
          ri_d    = rdata_q;
        end
        j_d     = j_q + IDX_W'(1);
        rd_addr = j_q + IDX_W'(1);
      end
      OP_WB: begin
        wr_en   = 1'b1;
        wr_addr = i_q;
        wr_data = ri_q;
        i_d     = i_q + IDX_W'(1);
        j_d     = i_q + IDX_W'(2);
        rd_addr = i_q + IDX_W'(1);
      end
      OP_EMIT: begin
        rd_addr = k_q;
        k_d     = k_q + IDX_W'(1);
        valid_d = 1'b1;
        end_d   = sts_o.emit_last;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      pair_mem[wr_addr] <= wr_data;
    end
    rdata_q <= pair_mem[rd_addr];
    ri_q    <= ri_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      n_q     <= '0;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
      valid_q <= 1'b0;
      end_q   <= 1'b0;
    end else begin
      fill_q  <= fill_d;
      n_q     <= n_d;
      i_q     <= i_d;
      j_q     <= j_d;
      k_q     <= k_d;
      valid_q <= valid_d;
      end_q   <= end_d;
    end
  end

  assign sorted_key_o   = rdata_q.key;
  assign sorted_tag_o   = rdata_q.tag;
  assign end_of_run_o   = end_q;
  assign result_valid_o = valid_q;

endmodule

// ----- hw/rtl/kts_ctrl.sv -----
// kts_ctrl: sequencer for loading, exchange sorting and read-out
module kts_ctrl import kts_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  input  logic final_item_i,
  input  sts_t sts_i,
  output cmd_t cmd_o,
  output logic busy
);

  localparam int ST_W = 3;
  localparam logic [ST_W-1:0] S_LOAD = 3'd0;
  localparam logic [ST_W-1:0] S_PREP = 3'd1;
  localparam logic [ST_W-1:0] S_LDI  = 3'd2;
  localparam logic [ST_W-1:0] S_CMP  = 3'd3;
  localparam logic [ST_W-1:0] S_WB   = 3'd4;
  localparam logic [ST_W-1:0] S_EMIT = 3'd5;

  logic [ST_W-1:0] state_q, state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o.store = 1'b0;
    cmd_o.close = 1'b0;
    cmd_o.op    = OP_NONE;
    unique case (state_q)
      S_LOAD: begin
        if (start) begin
          cmd_o.store = 1'b1;
          if (final_item_i) begin
            cmd_o.close = 1'b1;
            state_d     = sts_i.fill_nonzero ? S_PREP : S_EMIT;
          end
        end
      end
      S_PREP: begin
        cmd_o.op = OP_READ_I;
        state_d  = S_LDI;
      end
      S_LDI: begin
        cmd_o.op = OP_LOAD_I;
        state_d  = S_CMP;
      end
      S_CMP: begin
        cmd_o.op = OP_CMP;
        if (sts_i.inner_last) begin
          state_d = S_WB;
        end
      end
      S_WB: begin
        cmd_o.op = OP_WB;
        state_d  = sts_i.outer_last ? S_EMIT : S_LDI;
      end
      S_EMIT: begin
        cmd_o.op = OP_EMIT;
        if (sts_i.emit_last) begin
          state_d = S_LOAD;
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = state_q != S_LOAD;

endmodule

// ----- hw/rtl/key_tag_exchange_sorter.sv -----
// key_tag_exchange_sorter: top level joining the sequencer and the datapath
//
// Pairs are loaded one word per cycle while busy is low; the word with final_item_i set
// closes the set (at most 64 pairs are kept, later ones are dropped). The block then sorts
// the set in place and streams it out one word per cycle on result_valid_o, with
// end_of_run_o on the last word. Results cannot be held off. Busy stays high while the
// set is sorted and read out; the sort time is set by the compare loop over the
// single-write pair memory, which does one compare per cycle.
// A new set may start in the cycle that shows the last result.
module key_tag_exchange_sorter import kts_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic signed [KEY_W-1:0] sort_key_i,
  input  logic [TAG_W-1:0]        payload_tag_i,
  input  logic                    final_item_i,
  output logic signed [KEY_W-1:0] sorted_key_o,
  output logic [TAG_W-1:0]        sorted_tag_o,
  output logic                    end_of_run_o,
  output logic                    result_valid_o
);

  cmd_t cmd;
  sts_t sts;

  kts_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .final_item_i (final_item_i),
    .sts_i        (sts),
    .cmd_o        (cmd),
    .busy         (busy)
  );

  kts_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .sort_key_i     (sort_key_i),
    .payload_tag_i  (payload_tag_i),
    .sorted_key_o   (sorted_key_o),
    .sorted_tag_o   (sorted_tag_o),
    .end_of_run_o   (end_of_run_o),
    .result_valid_o (result_valid_o)
  );

endmodule

// ----- hw/rtl/kts_checker.sv -----
// kts_checker: port-level assertions for the sorter, bound to the top level
module kts_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic final_item_i,
  input logic end_of_run_o,
  input logic result_valid_o
);

  end_needs_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    end_of_run_o |-> result_valid_o)
    else $error("end_of_run_o without result strobe");

  close_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && final_item_i) |=> busy)
    else $error("closing word did not start the sort");

  load_stays_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && !final_item_i) |=> !busy)
    else $error("non-final word made the block busy");

  more_results_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !end_of_run_o) |-> busy)
    else $error("block idle with results still to come");

  no_result_on_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> !result_valid_o)
    else $error("result strobe in first busy cycle");

endmodule

bind key_tag_exchange_sorter kts_checker u_kts_checker (.*);
